### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high
`define CVM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds while reset is high
`define CVM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/cvm_pkg.sv
// Shared types and constants of the cell voltage monitor
package cvm_pkg;

   // item field widths
   localparam int CVM_CODE_W  = 14;
   localparam int CVM_GAIN_W  = 9;
   localparam int CVM_OFS_W   = 8;
   localparam int CVM_MV_W    = 16;
   localparam int CVM_CNT_W   = 8;
   localparam int CVM_POS_W   = 4;

   // frame length limit; a frame closes at position MAX_CELLS - 1 at the latest
   localparam int CVM_MAX_CELLS = 15;
   localparam logic [CVM_POS_W-1:0] CVM_LAST_POS = CVM_POS_W'(CVM_MAX_CELLS - 1);

   // scaling: mv = floor(code * gain / 1000); 1000 = 8 * 125
   localparam int CVM_PROD_W    = CVM_CODE_W + CVM_GAIN_W;
   localparam int CVM_DIV_SHIFT = 3;
   localparam int CVM_DVD_W     = CVM_PROD_W - CVM_DIV_SHIFT;
   // floor(y / 125) = (y * ceil(2^26 / 125)) >> 26, exact for y below 2^20
   localparam int CVM_RECIP_W     = 20;
   localparam int CVM_RECIP_SHIFT = 26;
   localparam logic [CVM_RECIP_W-1:0] CVM_RECIP = CVM_RECIP_W'(536871);
   localparam int CVM_RMUL_W = CVM_DVD_W + CVM_RECIP_W;
   localparam int CVM_QUOT_W = CVM_RMUL_W - CVM_RECIP_SHIFT;

   localparam logic [CVM_MV_W-1:0]  CVM_MV_CEIL = '1;
   localparam logic [CVM_CNT_W-1:0] CVM_CNT_MAX = '1;

   // register port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OVER_LIM   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNDER_LIM  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OVER_NEED  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_UNDER_NEED = 3'd5;

   // register reset values
   localparam logic [CVM_GAIN_W-1:0]       RST_GAIN       = 9'd380;
   localparam logic signed [CVM_OFS_W-1:0] RST_OFFSET     = 8'sd0;
   localparam logic [CVM_MV_W-1:0]         RST_OVER_LIM   = 16'd4300;
   localparam logic [CVM_MV_W-1:0]         RST_UNDER_LIM  = 16'd2500;
   localparam logic [CVM_CNT_W-1:0]        RST_OVER_NEED  = 8'd2;
   localparam logic [CVM_CNT_W-1:0]        RST_UNDER_NEED = 8'd8;

   typedef struct packed {
      logic [CVM_GAIN_W-1:0]       gain_microvolts;
      logic signed [CVM_OFS_W-1:0] offset_millivolts;
      logic [CVM_MV_W-1:0]         over_limit_mv;
      logic [CVM_MV_W-1:0]         under_limit_mv;
      logic [CVM_CNT_W-1:0]        over_frames_needed;
      logic [CVM_CNT_W-1:0]        under_frames_needed;
   } cvm_cfg_type;

   // scaled item handed from the scaler to the frame tracker
   typedef struct packed {
      logic [CVM_QUOT_W-1:0] quot;
      logic                  last_cell;
   } cvm_scaled_type;

endpackage

### hw/rtl/cell_voltage_monitor_unit.sv
// An accepted item passes the product, quotient and result registers in that order
// before rsp_valid rises with its result.
// Throughput: one item per cycle; the three registered stages advance independently,
// so bubbles close up and a waiting result does not block new items until all fill.
// Reset (synchronous, active high) empties the stages, restarts the frame (max 0,
// min 65535, position 0), clears both fault counters and restores register defaults.
module cell_voltage_monitor_unit import cvm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // register write port
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // cell code items
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CVM_CODE_W-1:0] req_raw_code,
   input  logic                  req_last_cell,
   // result items
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CVM_MV_W-1:0]   rsp_cell_mv,
   output logic [CVM_POS_W-1:0]  rsp_cell_number,
   output logic                  rsp_frame_done,
   output logic [CVM_MV_W-1:0]   rsp_frame_max_mv,
   output logic [CVM_MV_W-1:0]   rsp_frame_min_mv,
   output logic [CVM_CNT_W-1:0]  rsp_over_frames,
   output logic [CVM_CNT_W-1:0]  rsp_under_frames,
   output logic                  rsp_over_trip,
   output logic                  rsp_under_trip
);

   cvm_cfg_type    cfg;
   logic           scl_valid;
   logic           scl_stall;
   cvm_scaled_type scl_item;

   cvm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cvm_scale u_scale (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_raw_code  (req_raw_code),
      .req_last_cell (req_last_cell),
      .scl_valid     (scl_valid),
      .scl_stall     (scl_stall),
      .scl_item      (scl_item)
   );

   cvm_frame u_frame (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .scl_valid        (scl_valid),
      .scl_stall        (scl_stall),
      .scl_item         (scl_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cell_mv      (rsp_cell_mv),
      .rsp_cell_number  (rsp_cell_number),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_frame_max_mv (rsp_frame_max_mv),
      .rsp_frame_min_mv (rsp_frame_min_mv),
      .rsp_over_frames  (rsp_over_frames),
      .rsp_under_frames (rsp_under_frames),
      .rsp_over_trip    (rsp_over_trip),
      .rsp_under_trip   (rsp_under_trip)
   );

endmodule

### hw/rtl/cvm_csr.sv
// Configuration registers of the cell voltage monitor
module cvm_csr import cvm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cvm_cfg_type           cfg
);

   cvm_cfg_type cfg_ff;
   cvm_cfg_type cfg_in;

   // writes are always accepted
   assign csr_ready = 1'b1;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_GAIN:       cfg_in.gain_microvolts     = csr_wdata[CVM_GAIN_W-1:0];
            CSR_OFFSET:     cfg_in.offset_millivolts   = signed'(csr_wdata[CVM_OFS_W-1:0]);
            CSR_OVER_LIM:   cfg_in.over_limit_mv       = csr_wdata[CVM_MV_W-1:0];
            CSR_UNDER_LIM:  cfg_in.under_limit_mv      = csr_wdata[CVM_MV_W-1:0];
            CSR_OVER_NEED:  cfg_in.over_frames_needed  = csr_wdata[CVM_CNT_W-1:0];
            CSR_UNDER_NEED: cfg_in.under_frames_needed = csr_wdata[CVM_CNT_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_microvolts     <= RST_GAIN;
         cfg_ff.offset_millivolts   <= RST_OFFSET;
         cfg_ff.over_limit_mv       <= RST_OVER_LIM;
         cfg_ff.under_limit_mv      <= RST_UNDER_LIM;
         cfg_ff.over_frames_needed  <= RST_OVER_NEED;
         cfg_ff.under_frames_needed <= RST_UNDER_NEED;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/cvm_scale.sv
// Two-stage code scaler: code * gain, then divide by 1000
module cvm_scale import cvm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cvm_cfg_type           cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CVM_CODE_W-1:0] req_raw_code,
   input  logic                  req_last_cell,
   output logic                  scl_valid,
   input  logic                  scl_stall,
   output cvm_scaled_type        scl_item
);

   logic                  prod_valid_ff, prod_valid_in;
   logic [CVM_PROD_W-1:0] prod_ff, prod_in;
   logic                  prod_last_ff;
   logic                  quot_valid_ff, quot_valid_in;
   cvm_scaled_type        quot_ff, quot_in;
   logic                  load_prod, load_quot;
   logic [CVM_DVD_W-1:0]  dividend;
   logic [CVM_RMUL_W-1:0] recip_full;

   // stage flow: a stage loads when empty or when its item moves on
   assign load_quot = !quot_valid_ff || !scl_stall;
   assign load_prod = !prod_valid_ff || load_quot;
   assign req_stall = !load_prod;

   // stage 1: raw product in microvolts
   assign prod_in = CVM_PROD_W'(req_raw_code) * CVM_PROD_W'(cfg.gain_microvolts);
   assign prod_valid_in = load_prod ? req_valid : prod_valid_ff;

   // stage 2: /1000 as >>3 then /125 by reciprocal multiply
   assign dividend   = prod_ff[CVM_PROD_W-1:CVM_DIV_SHIFT];
   assign recip_full = CVM_RMUL_W'(dividend) * CVM_RMUL_W'(CVM_RECIP);
   assign quot_in.quot      = recip_full[CVM_RMUL_W-1:CVM_RECIP_SHIFT];
   assign quot_in.last_cell = prod_last_ff;
   assign quot_valid_in = load_quot ? prod_valid_ff : quot_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         quot_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         quot_valid_ff <= quot_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (load_prod) begin
         prod_ff      <= prod_in;
         prod_last_ff <= req_last_cell;
      end
      if (load_quot) begin
         quot_ff <= quot_in;
      end
   end

   assign scl_valid = quot_valid_ff;
   assign scl_item  = quot_ff;

endmodule

### hw/rtl/cvm_frame.sv
// Offset, clamp, frame min/max tracking, fault counters and result register
module cvm_frame import cvm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cvm_cfg_type           cfg,
   input  logic                  scl_valid,
   output logic                  scl_stall,
   input  cvm_scaled_type        scl_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CVM_MV_W-1:0]   rsp_cell_mv,
   output logic [CVM_POS_W-1:0]  rsp_cell_number,
   output logic                  rsp_frame_done,
   output logic [CVM_MV_W-1:0]   rsp_frame_max_mv,
   output logic [CVM_MV_W-1:0]   rsp_frame_min_mv,
   output logic [CVM_CNT_W-1:0]  rsp_over_frames,
   output logic [CVM_CNT_W-1:0]  rsp_under_frames,
   output logic                  rsp_over_trip,
   output logic                  rsp_under_trip
);

   localparam int SUM_W = CVM_MV_W + 1;

   logic                  valid_ff;
   logic [CVM_MV_W-1:0]   run_max_ff, run_max_in;
   logic [CVM_MV_W-1:0]   run_min_ff, run_min_in;
   logic [CVM_POS_W-1:0]  pos_ff, pos_in;
   logic [CVM_CNT_W-1:0]  over_ff, over_in;
   logic [CVM_CNT_W-1:0]  under_ff, under_in;

   logic                  load;
   logic signed [SUM_W-1:0] sum;
   logic [CVM_MV_W-1:0]   mv;
   logic [CVM_MV_W-1:0]   hi, lo;
   logic                  done;

   logic [CVM_MV_W-1:0]   mv_ff, max_ff, min_ff;
   logic [CVM_POS_W-1:0]  num_ff;
   logic                  done_ff, otrip_ff, utrip_ff;

   // result register takes an item when empty or being drained
   assign load      = scl_valid && (!valid_ff || !rsp_stall);
   assign scl_stall = valid_ff && rsp_stall;

   // add signed offset; quotient stays far below the 16-bit ceiling,
   // so only the negative side needs clamping
   assign sum = signed'({{(SUM_W-CVM_QUOT_W){1'b0}}, scl_item.quot})
              + {{(SUM_W-CVM_OFS_W){cfg.offset_millivolts[CVM_OFS_W-1]}},
                 cfg.offset_millivolts};
   assign mv  = sum[SUM_W-1] ? '0 : sum[CVM_MV_W-1:0];

   // running extremes, this cell included
   assign hi   = (mv > run_max_ff) ? mv : run_max_ff;
   assign lo   = (mv < run_min_ff) ? mv : run_min_ff;
   assign done = scl_item.last_cell || (pos_ff >= CVM_LAST_POS);

   // running state per cell; at frame close bump saturating counters, restart extremes and position
   always_comb begin
      over_in    = over_ff;
      under_in   = under_ff;
      run_max_in = hi;
      run_min_in = lo;
      pos_in     = pos_ff + 1'b1;
      if (done) begin
         if (hi > cfg.over_limit_mv && over_ff != CVM_CNT_MAX) begin
            over_in = over_ff + 1'b1;
         end
         if (lo < cfg.under_limit_mv && under_ff != CVM_CNT_MAX) begin
            under_in = under_ff + 1'b1;
         end
         run_max_in = '0;
         run_min_in = CVM_MV_CEIL;
         pos_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         run_max_ff <= '0;
         run_min_ff <= CVM_MV_CEIL;
         pos_ff     <= '0;
         over_ff    <= '0;
         under_ff   <= '0;
      end else begin
         if (load) begin
            valid_ff   <= 1'b1;
            run_max_ff <= run_max_in;
            run_min_ff <= run_min_in;
            pos_ff     <= pos_in;
            over_ff    <= over_in;
            under_ff   <= under_in;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         mv_ff    <= mv;
         num_ff   <= pos_ff;
         done_ff  <= done;
         max_ff   <= hi;
         min_ff   <= lo;
         otrip_ff <= (over_in >= cfg.over_frames_needed);
         utrip_ff <= (under_in >= cfg.under_frames_needed);
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_cell_mv      = mv_ff;
   assign rsp_cell_number  = num_ff;
   assign rsp_frame_done   = done_ff;
   assign rsp_frame_max_mv = max_ff;
   assign rsp_frame_min_mv = min_ff;
   assign rsp_over_frames  = over_ff;
   assign rsp_under_frames = under_ff;
   assign rsp_over_trip    = otrip_ff;
   assign rsp_under_trip   = utrip_ff;

endmodule

### hw/rtl/cvm_checker.sv
// Port-level checks for the cell voltage monitor, bound to the top level
`include "assert_macros.svh"

module cvm_checker import cvm_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [CVM_MV_W-1:0]  rsp_cell_mv,
   input logic [CVM_POS_W-1:0] rsp_cell_number,
   input logic                 rsp_frame_done,
   input logic [CVM_MV_W-1:0]  rsp_frame_max_mv,
   input logic [CVM_MV_W-1:0]  rsp_frame_min_mv
);

   // no result item survives reset
   `CVM_ASSERT_ALWAYS(a_rst_empty, clock, reset |=> !rsp_valid, "result valid after reset")

   // a stalled result item stays offered
   `CVM_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "result dropped")

   // the current cell always lies between the frame extremes
   `CVM_ASSERT(a_extremes, clock, reset,
      rsp_valid |-> (rsp_frame_max_mv >= rsp_cell_mv) && (rsp_cell_mv >= rsp_frame_min_mv),
      "cell outside frame extremes")

   // the last allowed position always closes the frame
   `CVM_ASSERT(a_frame_cap, clock, reset,
      rsp_valid && (rsp_cell_number >= CVM_LAST_POS) |-> rsp_frame_done,
      "frame overran its cell limit")

endmodule

bind cell_voltage_monitor_unit cvm_checker u_cvm_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_cell_mv      (rsp_cell_mv),
   .rsp_cell_number  (rsp_cell_number),
   .rsp_frame_done   (rsp_frame_done),
   .rsp_frame_max_mv (rsp_frame_max_mv),
   .rsp_frame_min_mv (rsp_frame_min_mv)
);
